// ----- hdl/ejs_pkg.sv -----
// ============================================================================
// ejs_pkg
// Shared codes and constants of the job scheduler: opcodes, policy codes and
// the layout of the configuration port.
// ============================================================================
package ejs_pkg;

    // Opcodes of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Selection policies. The unused code behaves as earliest deadline.
    localparam logic [1:0] POL_EDF  = 2'd0;
    localparam logic [1:0] POL_LSTF = 2'd1;
    localparam logic [1:0] POL_SJF  = 2'd2;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = 1'd1;

endpackage

// ----- hdl/ejs_job_if.sv -----
// ============================================================================
// ejs_job_if
// Input channel of the job scheduler: valid/ready handshake and the fields of
// one load or tick word.
// ============================================================================
interface ejs_job_if #(
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [ID_BITS-1:0]   job_id;
    logic [TIME_BITS-1:0] release_time;
    logic [TIME_BITS-1:0] exec_ticks;
    logic [TIME_BITS-1:0] job_deadline;

    modport source (
        output valid, opcode, job_id, release_time, exec_ticks, job_deadline,
        input  ready
    );
    modport sink (
        input  valid, opcode, job_id, release_time, exec_ticks, job_deadline,
        output ready
    );
endinterface

// ----- hdl/ejs_res_if.sv -----
// ============================================================================
// ejs_res_if
// Result channel of the job scheduler: valid/ready handshake and the fields
// of one result word.
// ============================================================================
interface ejs_res_if #(
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [ID_BITS-1:0]   running_id;
    logic                 idle;
    logic                 completed;
    logic [TIME_BITS-1:0] completion_time;
    logic [TIME_BITS-1:0] wait_ticks;
    logic                 missed;
    logic                 load_error;

    modport source (
        output valid, running_id, idle, completed, completion_time, wait_ticks,
               missed, load_error,
        input  ready
    );
    modport sink (
        input  valid, running_id, idle, completed, completion_time, wait_ticks,
               missed, load_error,
        output ready
    );
endinterface

// ----- hdl/ejs_entry_ram.sv -----
// ============================================================================
// ejs_entry_ram
// Job table storage: one write port and one read port with registered read
// data.
// ============================================================================
module ejs_entry_ram #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/edf_lstf_sjf_job_scheduler.sv -----
// ============================================================================
// edf_lstf_sjf_job_scheduler
// Single-processor job scheduler with a table of up to MAX_JOBS jobs, picking
// by earliest deadline, least slack or shortest job.
// ============================================================================
// A load word appends a job to the table and returns a result (load_error
// is set when the table is full). A tick word scans the loaded jobs one
// table entry per cycle through the single read port of the job table,
// feeding one shared key and compare unit, and returns its result after the
// scan; when a started job keeps the processor in non-preemptive mode the
// tick skips the scan. The input is ready only between items, and a
// finished result waits in an output register, so the next word is taken
// while the previous result is still unclaimed. Ties go to the lowest job
// id, then to the earliest loaded entry. Time saturates at its maximum
// value.
module edf_lstf_sjf_job_scheduler
#(
    parameter int MAX_JOBS  = 32,
    parameter int TIME_BITS = 16,
    parameter int ID_BITS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ejs_job_if.sink                       i_job,
    ejs_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [ejs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ejs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ejs_pkg::*;

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int KEY_W = TIME_BITS + 2;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct packed {
        logic                 fin;
        logic [TIME_BITS-1:0] done;
        logic [TIME_BITS-1:0] due;
        logic [TIME_BITS-1:0] exec;
        logic [TIME_BITS-1:0] rel;
        logic [ID_BITS-1:0]   id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_SCAN,
        ST_COMMIT,
        ST_FIN,
        ST_OUT
    } t_state;

    // Control state.
    t_state               r_state;
    logic [1:0]           r_policy;
    logic                 r_preempt;
    logic [CNT_W-1:0]     r_count;
    logic [TIME_BITS-1:0] r_now;
    logic [IDX_W-1:0]     r_cur_slot;
    logic                 r_busy;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_pend_vld;
    logic [IDX_W-1:0]     r_pend_slot;
    logic                 r_b_vld;
    logic                 r_o_valid;

    // Best candidate so far.
    logic [IDX_W-1:0]        r_b_slot;
    logic signed [KEY_W-1:0] r_b_key;
    logic [ID_BITS-1:0]      r_b_id;
    logic [TIME_BITS-1:0]    r_b_rel;
    logic [TIME_BITS-1:0]    r_b_exec;
    logic [TIME_BITS-1:0]    r_b_due;
    logic [TIME_BITS-1:0]    r_b_done;
    logic [TIME_BITS:0]      r_need;

    // Pending result and output register.
    logic [ID_BITS-1:0]   r_res_id;
    logic                 r_res_idle;
    logic                 r_res_completed;
    logic [TIME_BITS-1:0] r_res_ct;
    logic [TIME_BITS-1:0] r_res_wait;
    logic                 r_res_missed;
    logic                 r_res_lerr;
    logic [ID_BITS-1:0]   r_o_id;
    logic                 r_o_idle;
    logic                 r_o_completed;
    logic [TIME_BITS-1:0] r_o_ct;
    logic [TIME_BITS-1:0] r_o_wait;
    logic                 r_o_missed;
    logic                 r_o_lerr;

    // Table ports.
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    t_entry               w_wentry;
    logic [IDX_W-1:0]     w_raddr;
    logic [ENTRY_W-1:0]   w_rdata;
    t_entry               w_rentry;

    // Shared compare unit and commit arithmetic.
    logic                    w_accept;
    logic                    w_full;
    logic                    w_eligible;
    logic signed [KEY_W-1:0] w_key;
    logic                    w_better;
    logic                    w_cur_ok;
    logic [TIME_BITS-1:0]    n_now;
    logic [TIME_BITS-1:0]    n_done;
    logic                    n_fin;

    ejs_entry_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_JOBS),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rentry = t_entry'(w_rdata);
    assign w_accept = i_job.valid && i_job.ready;
    assign w_full   = (r_count == CNT_W'(MAX_JOBS));
    assign w_cur_ok = ({{(CNT_W-IDX_W){1'b0}}, r_cur_slot} < r_count);

    // Read address: the scan index while scanning, else the running job.
    assign w_raddr = (r_state == ST_SCAN) ? r_idx[IDX_W-1:0] : r_cur_slot;

    // Table write: a new job on load, updated progress on commit.
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_count[IDX_W-1:0];
        w_wentry = '{fin: 1'b0, done: '0, due: i_job.job_deadline,
                     exec: i_job.exec_ticks, rel: i_job.release_time,
                     id: i_job.job_id};
        if (r_state == ST_IDLE) begin
            w_we = w_accept && (i_job.opcode == OP_LOAD) && !w_full;
        end else if (r_state == ST_COMMIT) begin
            w_we     = r_b_vld;
            w_waddr  = r_b_slot;
            w_wentry = '{fin: n_fin, done: n_done, due: r_b_due, exec: r_b_exec,
                         rel: r_b_rel, id: r_b_id};
        end
    end

    // Sort key of the entry on the read port and the compare against the best.
    always_comb begin
        w_eligible = !w_rentry.fin && (w_rentry.rel <= r_now);
        case (r_policy)
            POL_LSTF: w_key = $signed({2'b00, w_rentry.due})
                            - $signed({2'b00, r_now})
                            - $signed({2'b00, w_rentry.exec})
                            + $signed({2'b00, w_rentry.done});
            POL_SJF:  w_key = $signed({2'b00, w_rentry.exec});
            default:  w_key = $signed({2'b00, w_rentry.due});
        endcase
        w_better = w_eligible && (!r_b_vld || (w_key < r_b_key) ||
                   ((w_key == r_b_key) && (w_rentry.id < r_b_id)));
    end

    // Saturating time and progress for the chosen job.
    always_comb begin
        n_now  = (r_now == TIME_MAX) ? r_now : r_now + 1'b1;
        n_done = (r_b_done == TIME_MAX) ? r_b_done : r_b_done + 1'b1;
        n_fin  = (n_done >= r_b_exec);
    end

    // Sequencer, scheduler state and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_policy   <= POL_EDF;
            r_preempt  <= 1'b1;
            r_count    <= '0;
            r_now      <= '0;
            r_cur_slot <= '0;
            r_busy     <= 1'b0;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_b_vld    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY:  r_policy  <= i_cfg_data[1:0];
                    CFG_PREEMPT: r_preempt <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // A claimed word leaves the output register unless a new one
            // replaces it in the same cycle.
            if (o_res.ready && (r_state != ST_OUT)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_res_id        <= '0;
                        r_res_idle      <= 1'b0;
                        r_res_completed <= 1'b0;
                        r_res_ct        <= '0;
                        r_res_wait      <= '0;
                        r_res_missed    <= 1'b0;
                        r_res_lerr      <= (i_job.opcode == OP_LOAD) && w_full;
                        r_b_vld         <= 1'b0;
                        r_idx           <= '0;
                        if (i_job.opcode == OP_LOAD) begin
                            if (!w_full) begin
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= ST_OUT;
                        end else if (!r_preempt && r_busy) begin
                            r_state <= ST_CHK;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end

                // Non-preemptive: keep the started job if it is still eligible.
                ST_CHK: begin
                    if (w_cur_ok && w_eligible) begin
                        r_b_vld  <= 1'b1;
                        r_b_slot <= r_cur_slot;
                        r_b_key  <= w_key;
                        r_b_id   <= w_rentry.id;
                        r_b_rel  <= w_rentry.rel;
                        r_b_exec <= w_rentry.exec;
                        r_b_due  <= w_rentry.due;
                        r_b_done <= w_rentry.done;
                        r_state  <= ST_COMMIT;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end

                // One entry issued and one entry compared per cycle.
                ST_SCAN: begin
                    if (r_pend_vld && w_better) begin
                        r_b_vld  <= 1'b1;
                        r_b_slot <= r_pend_slot;
                        r_b_key  <= w_key;
                        r_b_id   <= w_rentry.id;
                        r_b_rel  <= w_rentry.rel;
                        r_b_exec <= w_rentry.exec;
                        r_b_due  <= w_rentry.due;
                        r_b_done <= w_rentry.done;
                    end
                    if (r_idx < r_count) begin
                        r_pend_vld  <= 1'b1;
                        r_pend_slot <= r_idx[IDX_W-1:0];
                        r_idx       <= r_idx + 1'b1;
                    end else begin
                        r_pend_vld <= 1'b0;
                        r_state    <= ST_COMMIT;
                    end
                end

                // Run the chosen job for one tick and advance time.
                ST_COMMIT: begin
                    r_now  <= n_now;
                    r_need <= {1'b0, r_b_rel} + {1'b0, r_b_exec};
                    if (!r_b_vld) begin
                        r_busy     <= 1'b0;
                        r_res_idle <= 1'b1;
                    end else begin
                        r_res_id <= r_b_id;
                        if (n_fin) begin
                            r_busy          <= 1'b0;
                            r_res_completed <= 1'b1;
                            r_res_ct        <= n_now;
                            r_res_missed    <= (n_now > r_b_due);
                        end else begin
                            r_busy     <= 1'b1;
                            r_cur_slot <= r_b_slot;
                        end
                    end
                    r_state <= ST_FIN;
                end

                // Wait time of a completed job, clamped at zero.
                ST_FIN: begin
                    if (r_res_completed && ({1'b0, r_now} > r_need)) begin
                        r_res_wait <= TIME_BITS'({1'b0, r_now} - r_need);
                    end
                    r_state <= ST_OUT;
                end

                // Hand the result to the output register once it is free.
                ST_OUT: begin
                    if (!r_o_valid || o_res.ready) begin
                        r_o_valid     <= 1'b1;
                        r_o_id        <= r_res_id;
                        r_o_idle      <= r_res_idle;
                        r_o_completed <= r_res_completed;
                        r_o_ct        <= r_res_ct;
                        r_o_wait      <= r_res_wait;
                        r_o_missed    <= r_res_missed;
                        r_o_lerr      <= r_res_lerr;
                        r_state       <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Channel outputs.
    assign i_job.ready           = (r_state == ST_IDLE);
    assign o_res.valid           = r_o_valid;
    assign o_res.running_id      = r_o_id;
    assign o_res.idle            = r_o_idle;
    assign o_res.completed       = r_o_completed;
    assign o_res.completion_time = r_o_ct;
    assign o_res.wait_ticks      = r_o_wait;
    assign o_res.missed          = r_o_missed;
    assign o_res.load_error      = r_o_lerr;

`ifndef ASSERT_OFF
    // The table never holds more jobs than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS))
        else $error("job count exceeds table depth");

    // A job that holds the processor is always a loaded entry.
    a_busy_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> w_cur_ok)
        else $error("running job slot is not loaded");

    // A result word carries at most one of idle, completion and load error.
    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> $onehot0({o_res.idle, o_res.completed, o_res.load_error}))
        else $error("result word has conflicting flags");

    // An idle tick reports no job.
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.idle) |-> (o_res.running_id == '0))
        else $error("idle tick reports a job id");
`endif
endmodule
